// File: hw/rtl/mss_pkg.sv
// Shared types and constants for the multi-stack shared store.
// Item and result words, status codes, configuration register indexes.
// No dependencies.
`default_nettype none

package mss_pkg;

    localparam int VALUE_W     = 32;
    localparam int SID_W       = 3;
    localparam int FILL_W      = 8;
    localparam int COUNT_W     = 4;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 8;
    // wide enough for stack * slots + fill and for a 4096-word depth
    localparam int ADDR_CALC_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_STACK_COUNT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS       = 4'd1;

    localparam logic [COUNT_W-1:0] STACK_COUNT_RESET = 4'd1;
    localparam logic [FILL_W-1:0]  SLOTS_RESET       = 8'd16;

    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_BAD   = 2'd3
    } t_status;

    typedef struct packed {
        logic                      action;
        logic [SID_W-1:0]          stack_id;
        logic signed [VALUE_W-1:0] push_value;
    } t_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] pop_value;
        logic [1:0]                status;
    } t_result;

    // memory request and result bookkeeping from control to the top level
    typedef struct packed {
        logic    we;
        logic    re;
        logic    pop_live;
        t_status status;
    } t_issue;

endpackage

`default_nettype wire

// File: hw/rtl/multi_stack_shared_store.sv
// Top level of the multi-stack shared store: control, data RAM, result stage.
// Depends on mss_pkg, mss_ctrl and mss_ram.
`default_nettype none

// Several LIFO stacks share one data RAM of MEM_DEPTH words. Stack s owns the
// partition starting at word s * slots_per_stack.
//
// Command channel: present a word on i_item and raise start; it is taken at
// the rising edge where start is high and busy is low. Each command returns
// exactly one result word on o_result, flagged by o_done for one cycle, in the
// cycle after it was taken. The receiver cannot stall; the result must be
// captured in that cycle.
//
// Throughput: one command per cycle unless busy. A push writes its word at
// the accepting edge and a pop reads through the RAM's registered read
// port, so a pop that follows a push to the same stack already sees the new
// word. Fill counts live in flip-flops and update at the accepting edge.
//
// Configuration: the cfg channel is always ready; index 0 is stack_count,
// index 1 slots_per_stack, others are ignored. Write only with no command in flight.
//
// Reset (synchronous, active low): every stack empty, stack_count 1,
// slots_per_stack 16, RAM contents kept. busy is registered: high in reset,
// it falls at the clock edge that samples reset released.

module multi_stack_shared_store #(
    parameter int MEM_DEPTH  = 128,
    parameter int MAX_STACKS = 8
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire mss_pkg::t_item                 i_item,
    output logic                                o_done,
    output mss_pkg::t_result                    o_result,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [mss_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [mss_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(MEM_DEPTH);

    logic            r_up;
    logic            r_done;
    logic            r_pop_live;
    logic [1:0]      r_status;
    logic            accept;
    mss_pkg::t_issue issue;
    logic [AW-1:0]   addr;
    logic [mss_pkg::VALUE_W-1:0] rdata;

    assign busy        = !r_up;
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;

    mss_ctrl #(
        .MEM_DEPTH  (MEM_DEPTH),
        .MAX_STACKS (MAX_STACKS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_item      (i_item),
        .o_issue     (issue),
        .o_addr      (addr)
    );

    // one port: a push writes, a pop reads, never both
    mss_ram #(
        .WIDTH (mss_pkg::VALUE_W),
        .DEPTH (MEM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (issue.we),
        .i_re    (issue.re),
        .i_addr  (addr),
        .i_wdata (i_item.push_value),
        .o_rdata (rdata)
    );

    // hold the status beside the RAM read so both land in the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_up   <= 1'b1;
            r_done <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status   <= issue.status;
            r_pop_live <= issue.pop_live;
        end
    end

    always_comb begin
        o_done             = r_done;
        o_result.status    = r_status;
        // drop RAM data unless this word is a successful pop inside memory
        o_result.pop_value = r_pop_live ? rdata : '0;
    end

endmodule

`default_nettype wire

// File: hw/rtl/mss_ram.sv
// Generic single-port synchronous RAM with registered read.
// Depends on nothing.
`default_nettype none

module mss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: hw/rtl/mss_ctrl.sv
// Stack control: configuration registers, per-stack fill counts, address
// and status decode. Depends on mss_pkg.
`default_nettype none

module mss_ctrl #(
    parameter int MEM_DEPTH  = 128,
    parameter int MAX_STACKS = 8
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_valid,
    input  wire logic [mss_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [mss_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  wire logic                                i_accept,
    input  wire mss_pkg::t_item                      i_item,
    output mss_pkg::t_issue                          o_issue,
    output logic [$clog2(MEM_DEPTH)-1:0]             o_addr
);

    localparam int AW  = $clog2(MEM_DEPTH);
    localparam int CW  = mss_pkg::ADDR_CALC_W;
    localparam int FW  = mss_pkg::FILL_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(MEM_DEPTH);
    localparam logic [4:0]    MAX_C   = 5'(MAX_STACKS);

    logic [mss_pkg::COUNT_W-1:0] r_count;
    logic [FW-1:0]               r_slots;
    logic [FW-1:0]               r_fill [MAX_STACKS];

    logic [4:0]      live;
    logic            bad;
    logic [FW-1:0]   fill;
    logic [CW-1:0]   base;
    logic [CW-1:0]   push_addr;
    logic [CW-1:0]   pop_addr;
    logic            push_ok;
    logic            pop_ok;
    mss_pkg::t_issue issue;

    always_comb begin
        live = ({1'b0, r_count} > MAX_C) ? MAX_C : {1'b0, r_count};
        bad  = {2'b00, i_item.stack_id} >= live;

        fill = '0;
        for (int i = 0; i < MAX_STACKS; i++) begin
            if (5'(i) == {2'b00, i_item.stack_id}) begin
                fill = r_fill[i];
            end
        end

        base      = CW'(i_item.stack_id) * CW'(r_slots);
        push_addr = base + CW'(fill);
        pop_addr  = base + CW'(fill) - CW'(1);

        push_ok = 1'b0;
        pop_ok  = 1'b0;
        issue   = '{we: 1'b0, re: 1'b0, pop_live: 1'b0, status: mss_pkg::ST_OK};

        if (bad) begin
            issue.status = mss_pkg::ST_BAD;
        end else if (i_item.action == mss_pkg::ACT_PUSH) begin
            if (fill >= r_slots || push_addr >= DEPTH_C) begin
                issue.status = mss_pkg::ST_FULL;
            end else begin
                push_ok  = 1'b1;
                issue.we = i_accept;
            end
        end else begin
            if (fill == '0) begin
                issue.status = mss_pkg::ST_EMPTY;
            end else begin
                pop_ok = 1'b1;
                // a word past the memory end pops as zero
                issue.pop_live = pop_addr < DEPTH_C;
                issue.re       = i_accept && (pop_addr < DEPTH_C);
            end
        end

        o_addr  = (i_item.action == mss_pkg::ACT_PUSH) ? push_addr[AW-1:0]
                                                       : pop_addr[AW-1:0];
        o_issue = issue;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= mss_pkg::STACK_COUNT_RESET;
            r_slots <= mss_pkg::SLOTS_RESET;
            for (int i = 0; i < MAX_STACKS; i++) begin
                r_fill[i] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == mss_pkg::CFG_STACK_COUNT) begin
                    r_count <= i_cfg_data[mss_pkg::COUNT_W-1:0];
                end else if (i_cfg_index == mss_pkg::CFG_SLOTS) begin
                    r_slots <= i_cfg_data[FW-1:0];
                end
            end
            if (i_accept) begin
                for (int i = 0; i < MAX_STACKS; i++) begin
                    if (5'(i) == {2'b00, i_item.stack_id}) begin
                        if (push_ok) begin
                            r_fill[i] <= fill + FW'(1);
                        end else if (pop_ok) begin
                            r_fill[i] <= fill - FW'(1);
                        end
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: tb/multi_stack_shared_store_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for multi_stack_shared_store: directed and random push/pop words.
// Depends on mss_pkg and the multi_stack_shared_store RTL.

module multi_stack_shared_store_tb;

    localparam int MEM_DEPTH  = 128;
    localparam int MAX_STACKS = 8;

    localparam int VALUE_W    = mss_pkg::VALUE_W;
    localparam int SID_W      = mss_pkg::SID_W;
    localparam int FILL_W     = mss_pkg::FILL_W;
    localparam int COUNT_W    = mss_pkg::COUNT_W;
    localparam int CFG_IDX_W  = mss_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = mss_pkg::CFG_DATA_W;

    // indexes past the register list; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LOW = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_TOP = 4'd15;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    mss_pkg::t_item        i_item;
    logic                  o_done;
    mss_pkg::t_result      o_result;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    multi_stack_shared_store #(
        .MEM_DEPTH (MEM_DEPTH),
        .MAX_STACKS(MAX_STACKS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_done     (o_done),
        .o_result   (o_result),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    // 2 ns clock
    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow of the block: memory words, which words hold data, fill
    // levels and the two configuration registers.
    // ------------------------------------------------------------------
    logic [VALUE_W-1:0] shadow_mem [MEM_DEPTH];
    bit                 word_written [MEM_DEPTH];
    logic [FILL_W-1:0]  fill_level [MAX_STACKS];
    logic [COUNT_W-1:0] cfg_stack_count;
    logic [FILL_W-1:0]  cfg_slots;

    // results still owed by the block, oldest first
    mss_pkg::t_result pending_outcomes[$];
    int               mismatch_count;

    // Stack count saturates at the number of stacks built in.
    function automatic int live_stack_count();
        return (int'(cfg_stack_count) > MAX_STACKS) ? MAX_STACKS : int'(cfg_stack_count);
    endfunction

    // Apply one push or pop to the shadow and return the word the block owes.
    function automatic mss_pkg::t_result stack_op_outcome(mss_pkg::t_item it);
        mss_pkg::t_result r;
        int               sid;
        int               fill;
        int               base;
        int               addr;
        sid         = int'(it.stack_id);
        r.pop_value = '0;
        r.status    = mss_pkg::ST_OK;
        if (sid >= live_stack_count()) begin
            r.status = mss_pkg::ST_BAD;
        end else begin
            fill = int'(fill_level[sid]);
            base = sid * int'(cfg_slots);
            if (it.action == mss_pkg::ACT_PUSH) begin
                addr = base + fill;
                // full partition, or a partition running past the memory
                if (fill >= int'(cfg_slots) || addr >= MEM_DEPTH) begin
                    r.status = mss_pkg::ST_FULL;
                end else begin
                    shadow_mem[addr]   = it.push_value;
                    word_written[addr] = 1'b1;
                    fill_level[sid]    = FILL_W'(fill + 1);
                end
            end else begin
                if (fill == 0) begin
                    r.status = mss_pkg::ST_EMPTY;
                end else begin
                    addr = base + fill - 1;
                    // a top beyond the memory pops as zero but still succeeds
                    if (addr < MEM_DEPTH)
                        r.pop_value = shadow_mem[addr];
                    fill_level[sid] = FILL_W'(fill - 1);
                end
            end
        end
        return r;
    endfunction

    // A pop is legal stimulus unless it would read a word never written,
    // which can only happen after the partition size changed under data.
    function automatic bit pop_reads_known_word(logic [SID_W-1:0] sid);
        int addr;
        if (int'(sid) >= live_stack_count() || fill_level[sid] == '0)
            return 1'b1;
        addr = int'(sid) * int'(cfg_slots) + int'(fill_level[sid]) - 1;
        return (addr >= MEM_DEPTH) || word_written[addr];
    endfunction

    // ------------------------------------------------------------------
    // Drivers. All tasks are entered and left at a falling edge.
    // ------------------------------------------------------------------

    // Send one command word after a random gap; leave start high so that a
    // following word with no gap goes back to back.
    task automatic send_word(logic act, logic [SID_W-1:0] sid,
                             logic [VALUE_W-1:0] value);
        mss_pkg::t_item it;
        int             gap;
        it.action     = act;
        it.stack_id   = sid;
        it.push_value = value;
        gap           = $urandom_range(0, 4);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        // hold until the block takes the word
        forever begin
            @(posedge i_clk);
            if (!busy)
                break;
        end
        pending_outcomes.push_back(stack_op_outcome(it));
        @(negedge i_clk);
    endtask

    // Drop start and wait until every owed result has come back.
    task automatic drain_replies();
        start <= 1'b0;
        while (pending_outcomes.size() > 0)
            @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    // Write one configuration register; call only while the block is idle.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready)
                break;
        end
        if (idx == mss_pkg::CFG_STACK_COUNT)
            cfg_stack_count = data[COUNT_W-1:0];
        else if (idx == mss_pkg::CFG_SLOTS)
            cfg_slots = data;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Result checker: every o_done word must match the oldest owed result.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        mss_pkg::t_result want;
        if (i_rst_n && o_done) begin
            if (pending_outcomes.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result word, expected none, %s %h status %0d",
                         $time, "actual pop_value", o_result.pop_value,
                         o_result.status);
            end else begin
                want = pending_outcomes.pop_front();
                if (o_result.pop_value !== want.pop_value) begin
                    mismatch_count++;
                    $display("%0t: pop_value mismatch, expected %h, actual %h",
                             $time, want.pop_value, o_result.pop_value);
                end
                if (o_result.status !== want.status) begin
                    mismatch_count++;
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, want.status, o_result.status);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset settings (one stack, 16 slots): empty pop, LIFO order with the
    // value extremes, a push then a pop, stack numbers out of range.
    task automatic test_reset_settings();
        send_word(mss_pkg::ACT_POP,  3'd0, 32'h0000_1234);
        send_word(mss_pkg::ACT_PUSH, 3'd0, 32'h7FFF_FFFF);
        send_word(mss_pkg::ACT_PUSH, 3'd0, 32'h8000_0000);
        send_word(mss_pkg::ACT_POP,  3'd0, 32'hFFFF_FFFF);
        send_word(mss_pkg::ACT_POP,  3'd0, 32'h0000_0000);
        send_word(mss_pkg::ACT_PUSH, 3'd7, 32'hFFFF_FFFF);
        send_word(mss_pkg::ACT_POP,  3'd1, 32'h0000_0000);
        drain_replies();
    endtask

    // Boundary settings: saturated stack count, one slot, zero slots, zero
    // stacks, a partition past the memory and writes to unused indexes.
    task automatic test_boundaries();
        // count 15 saturates to eight stacks
        write_reg(mss_pkg::CFG_STACK_COUNT, 8'hFF);
        write_reg(mss_pkg::CFG_SLOTS, 8'd1);
        send_word(mss_pkg::ACT_PUSH, 3'd7, 32'hFFFF_FFFF);
        send_word(mss_pkg::ACT_PUSH, 3'd7, 32'h0000_0001);
        send_word(mss_pkg::ACT_POP,  3'd7, 32'h0000_0000);
        drain_replies();

        // zero slots: every push overflows
        write_reg(mss_pkg::CFG_SLOTS, 8'd0);
        send_word(mss_pkg::ACT_PUSH, 3'd3, 32'h1234_5678);
        send_word(mss_pkg::ACT_POP,  3'd3, 32'h0000_0000);
        drain_replies();

        // zero stacks: every stack number is bad
        write_reg(mss_pkg::CFG_STACK_COUNT, 8'd0);
        send_word(mss_pkg::ACT_PUSH, 3'd0, 32'h0000_0000);
        send_word(mss_pkg::ACT_POP,  3'd0, 32'h0000_0000);
        drain_replies();

        // full-size partitions: stack 1 starts past the end of memory
        write_reg(mss_pkg::CFG_STACK_COUNT, 8'd8);
        write_reg(mss_pkg::CFG_SLOTS, 8'd128);
        send_word(mss_pkg::ACT_PUSH, 3'd1, 32'h0F0F_0F0F);
        send_word(mss_pkg::ACT_PUSH, 3'd0, 32'h5A5A_5A5A);
        drain_replies();

        // unused indexes must leave both registers alone
        write_reg(CFG_UNUSED_TOP, 8'hFF);
        write_reg(CFG_UNUSED_LOW, 8'h00);
        send_word(mss_pkg::ACT_POP, 3'd0, 32'h0000_0000);
        drain_replies();
    endtask

    // Random phases, each under its own settings. Fill levels carry over
    // from phase to phase, so data is re-addressed under new partitions.
    task automatic test_random_phases(int phases, int words_per_phase);
        logic [COUNT_W-1:0]    count;
        logic [CFG_DATA_W-1:0] slots;
        logic                  act;
        logic [SID_W-1:0]      sid;
        logic [VALUE_W-1:0]    value;
        int                    push_pct;
        int                    live;
        for (int p = 0; p < phases; p++) begin
            // the extremes first, then random settings
            case (p)
                0: begin count = 4'd1;  slots = 8'd1;   end
                1: begin count = 4'd8;  slots = 8'd128; end
                2: begin count = 4'd8;  slots = 8'd16;  end
                3: begin count = 4'd15; slots = 8'd4;   end
                default: begin
                    case ($urandom_range(0, 9))
                        0:       count = 4'd0;
                        1:       count = 4'($urandom_range(9, 15));
                        default: count = 4'($urandom_range(1, 8));
                    endcase
                    case ($urandom_range(0, 9))
                        0:       slots = 8'd0;
                        1:       slots = 8'($urandom_range(129, 255));
                        2, 3:    slots = 8'($urandom_range(9, 128));
                        default: slots = 8'($urandom_range(1, 8));
                    endcase
                end
            endcase
            // upper nibble of the count write is don't-care
            write_reg(mss_pkg::CFG_STACK_COUNT, {4'($urandom_range(0, 15)), count});
            write_reg(mss_pkg::CFG_SLOTS, slots);
            live     = live_stack_count();
            push_pct = $urandom_range(25, 75);
            for (int n = 0; n < words_per_phase; n++) begin
                act = ($urandom_range(0, 99) < push_pct) ? mss_pkg::ACT_PUSH
                                                         : mss_pkg::ACT_POP;
                if (live > 0 && $urandom_range(0, 9) < 8)
                    sid = SID_W'($urandom_range(0, live - 1));
                else
                    sid = SID_W'($urandom_range(0, 7));
                case ($urandom_range(0, 9))
                    0:       value = 32'h8000_0000;
                    1:       value = 32'h7FFF_FFFF;
                    2:       value = 32'hFFFF_FFFF;
                    3:       value = 32'h0000_0000;
                    default: value = $urandom();
                endcase
                // never pop a word that was never written
                if (act == mss_pkg::ACT_POP && !pop_reads_known_word(sid))
                    act = mss_pkg::ACT_PUSH;
                send_word(act, sid, value);
            end
            drain_replies();
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        start           = 1'b0;
        i_item          = '0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        i_rst_n         = 1'b0;
        mismatch_count  = 0;
        cfg_stack_count = mss_pkg::STACK_COUNT_RESET;
        cfg_slots       = mss_pkg::SLOTS_RESET;
        for (int s = 0; s < MAX_STACKS; s++)
            fill_level[s] = '0;
        for (int a = 0; a < MEM_DEPTH; a++) begin
            shadow_mem[a]   = '0;
            word_written[a] = 1'b0;
        end

        // hold reset low from the start, release it at a falling edge
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_settings();
        test_boundaries();
        test_random_phases(10, 50);

        drain_replies();
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial begin
        #400000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
